>>> hdl/jts_pkg.sv
// Shared types and constants for the JSON token scanner.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package jts_pkg;

    // Scanner modes between and inside tokens
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_KEYWORD = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_INT     = 3'd3,
        MODE_DOT     = 3'd4,
        MODE_FRAC    = 3'd5,
        MODE_GARBAGE = 3'd6
    } mode_t;

    // Token type codes
    localparam logic [3:0] TOK_LBRACE   = 4'd0;
    localparam logic [3:0] TOK_RBRACE   = 4'd1;
    localparam logic [3:0] TOK_LBRACKET = 4'd2;
    localparam logic [3:0] TOK_RBRACKET = 4'd3;
    localparam logic [3:0] TOK_COLON    = 4'd4;
    localparam logic [3:0] TOK_COMMA    = 4'd5;
    localparam logic [3:0] TOK_STRING   = 4'd6;
    localparam logic [3:0] TOK_NUMBER   = 4'd7;
    localparam logic [3:0] TOK_TRUE     = 4'd8;
    localparam logic [3:0] TOK_FALSE    = 4'd9;
    localparam logic [3:0] TOK_NULL     = 4'd10;
    localparam logic [3:0] TOK_EOF      = 4'd11;
    localparam logic [3:0] TOK_GARBAGE  = 4'd12;

    // Output stream data width: content byte and token type, padded to bytes
    localparam int TDATA_W = 16;

    // Default depth of the queue between scanner and output serializer
    localparam int QUEUE_DEPTH = 4;

    // One result item
    typedef struct packed {
        logic       ev;      // 0 content byte, 1 token complete
        logic [7:0] data;
        logic [3:0] ttype;
    } result_t;

    // All results of one input item: one, or two when two is set
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/json_token_scanner.sv
// JSON token scanner top level: scanner front end, entry queue and
// output serializer. Uses jts_pkg, jts_front, jts_fifo and jts_back.
//
// Streaming JSON lexer. Feed one text byte per item (s_tuser low) and an
// end-of-input item (s_tuser high). Each token comes out as its content
// bytes (m_tuser low, byte in m_tdata[7:0]) followed by one
// token-complete item (m_tuser high, type in m_tdata[11:8]); m_tlast
// marks the final result caused by an input item. Punctuation gives only
// the complete item; string quotes are not sent. The input side takes
// one byte per cycle while the queue has room. The output side sends one
// result per cycle while m_tready is high and entries are queued; a
// byte that ends one token and starts another, or an end of input that
// closes a token, gives two results, sent in turn; the serializer sets the
// sustained rate at one result per cycle. A result passes through the
// queue and the serializer's hold register before it is presented.
`default_nettype none

module json_token_scanner #(
    parameter int QUEUE_DEPTH = jts_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] text_byte
    input  wire logic                          s_tuser,   // [0] kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [jts_pkg::TDATA_W-1:0]        m_tdata,   // [7:0] content_byte, [11:8] token_type
    output logic                               m_tuser,   // [0] event_res
    output logic                               m_tlast
);
    import jts_pkg::*;

    logic   push, full, pop, empty;
    entry_t push_entry, pop_entry;

    jts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .kind       (s_tuser),
        .text_byte  (s_tdata),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    jts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    jts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/jts_front.sv
// Scanner front end: accepts text bytes, tracks the lexer mode and
// packs the results of each byte into one queue entry. Uses jts_pkg.
`default_nettype none

module jts_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic            kind,
    input  wire logic [7:0]      text_byte,
    input  wire logic            full,
    output logic                 push,
    output jts_pkg::entry_t      push_entry
);
    import jts_pkg::*;

    // Character codes
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    // Keyword targets
    localparam logic [1:0] KW_NONE  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;
    localparam logic [1:0] KW_NULL  = 2'd3;

    localparam logic [2:0] POS_MAX = 3'd7;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] tg);
        logic [2:0] n;
        case (tg)
            KW_TRUE:  n = 3'd4;
            KW_FALSE: n = 3'd5;
            KW_NULL:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] kw_type(input logic [1:0] tg);
        logic [3:0] t;
        case (tg)
            KW_TRUE:  t = TOK_TRUE;
            KW_FALSE: t = TOK_FALSE;
            KW_NULL:  t = TOK_NULL;
            default:  t = TOK_GARBAGE;
        endcase
        return t;
    endfunction

    // Expected keyword letter at a position; zero past the end
    function automatic logic [7:0] kw_char(input logic [1:0] tg, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        case (tg)
            KW_TRUE:
                case (p)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            KW_FALSE:
                case (p)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            KW_NULL:
                case (p)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic result_t content_res(input logic [7:0] c);
        result_t r;
        r.ev    = 1'b0;
        r.data  = c;
        r.ttype = 4'd0;
        return r;
    endfunction

    function automatic result_t complete_res(input logic [3:0] t);
        result_t r;
        r.ev    = 1'b1;
        r.data  = 8'h00;
        r.ttype = t;
        return r;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [1:0] kw_target_reg, kw_target_next;
    logic [2:0] kw_pos_reg, kw_pos_next;
    logic       kw_match_reg, kw_match_next;
    logic       lead_zero_reg, lead_zero_next;
    logic       int_over_one_reg, int_over_one_next;

    // Token start decode for the current byte
    mode_t      b_mode;
    logic [1:0] b_target;
    logic [2:0] b_pos;
    logic       b_match;
    logic       b_lead_zero;
    logic       b_has;
    result_t    b_res;

    logic [3:0] fin_type;
    logic       kw_hit;
    logic       has_res;
    entry_t     ent;
    logic       accept;

    assign s_tready   = !full;
    assign accept     = s_tvalid && s_tready;
    assign push       = accept && has_res;
    assign push_entry = ent;

    // Decode the byte as the start of a new token
    always_comb
    begin
        b_mode      = MODE_IDLE;
        b_target    = KW_NONE;
        b_pos       = 3'd0;
        b_match     = 1'b0;
        b_lead_zero = 1'b0;
        b_has       = 1'b0;
        b_res       = content_res(text_byte);
        if (is_space(text_byte))
        begin
            b_has = 1'b0;
        end
        else
        begin
            case (text_byte)
                CH_LBRACE:
                begin
                    b_has = 1'b1;
                    b_res = complete_res(TOK_LBRACE);
                end
                CH_RBRACE:
                begin
                    b_has = 1'b1;
                    b_res = complete_res(TOK_RBRACE);
                end
                CH_LBRACKET:
                begin
                    b_has = 1'b1;
                    b_res = complete_res(TOK_LBRACKET);
                end
                CH_RBRACKET:
                begin
                    b_has = 1'b1;
                    b_res = complete_res(TOK_RBRACKET);
                end
                CH_COLON:
                begin
                    b_has = 1'b1;
                    b_res = complete_res(TOK_COLON);
                end
                CH_COMMA:
                begin
                    b_has = 1'b1;
                    b_res = complete_res(TOK_COMMA);
                end
                CH_T, CH_F, CH_N:
                begin
                    b_mode   = MODE_KEYWORD;
                    b_target = (text_byte == CH_T) ? KW_TRUE :
                               (text_byte == CH_F) ? KW_FALSE : KW_NULL;
                    b_pos    = 3'd1;
                    b_match  = 1'b1;
                    b_has    = 1'b1;
                end
                CH_QUOTE:
                begin
                    b_mode = MODE_STRING;
                end
                default:
                begin
                    b_has = 1'b1;
                    if (is_digit(text_byte))
                    begin
                        b_mode      = MODE_INT;
                        b_lead_zero = (text_byte == CH_ZERO);
                    end
                    else
                    begin
                        b_mode = MODE_GARBAGE;
                    end
                end
            endcase
        end
    end

    // Type of the pending token if it is cut off now
    always_comb
    begin
        kw_hit   = kw_match_reg && (kw_pos_reg == kw_len(kw_target_reg));
        fin_type = TOK_GARBAGE;
        case (mode_reg)
            MODE_KEYWORD:
                fin_type = kw_hit ? kw_type(kw_target_reg) : TOK_GARBAGE;
            MODE_INT, MODE_FRAC:
                fin_type = (lead_zero_reg && int_over_one_reg) ? TOK_GARBAGE : TOK_NUMBER;
            default:
                fin_type = TOK_GARBAGE;
        endcase
    end

    // Next mode and the results of this byte
    always_comb
    begin
        mode_next         = mode_reg;
        kw_target_next    = kw_target_reg;
        kw_pos_next       = kw_pos_reg;
        kw_match_next     = kw_match_reg;
        lead_zero_next    = lead_zero_reg;
        int_over_one_next = int_over_one_reg;
        has_res           = 1'b0;
        ent               = '0;

        if (kind)
        begin
            // End of input: close any open token, then give eof
            mode_next         = MODE_IDLE;
            kw_target_next    = KW_NONE;
            kw_pos_next       = 3'd0;
            kw_match_next     = 1'b0;
            lead_zero_next    = 1'b0;
            int_over_one_next = 1'b0;
            has_res           = 1'b1;
            if (mode_reg >= MODE_KEYWORD && mode_reg <= MODE_GARBAGE)
            begin
                ent.two = 1'b1;
                ent.r0  = complete_res(fin_type);
                ent.r1  = complete_res(TOK_EOF);
            end
            else
            begin
                ent.r0 = complete_res(TOK_EOF);
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_KEYWORD:
                begin
                    if (is_alpha(text_byte))
                    begin
                        if (kw_pos_reg >= kw_len(kw_target_reg) ||
                            kw_char(kw_target_reg, kw_pos_reg) != text_byte)
                            kw_match_next = 1'b0;
                        if (kw_pos_reg != POS_MAX)
                            kw_pos_next = kw_pos_reg + 3'd1;
                        has_res = 1'b1;
                        ent.r0  = content_res(text_byte);
                    end
                    else
                    begin
                        mode_next         = b_mode;
                        kw_target_next    = b_target;
                        kw_pos_next       = b_pos;
                        kw_match_next     = b_match;
                        lead_zero_next    = b_lead_zero;
                        int_over_one_next = 1'b0;
                        has_res           = 1'b1;
                        ent.two           = b_has;
                        ent.r0            = complete_res(fin_type);
                        ent.r1            = b_res;
                    end
                end
                MODE_STRING:
                begin
                    has_res = 1'b1;
                    if (text_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_IDLE;
                        ent.r0    = complete_res(TOK_STRING);
                    end
                    else
                    begin
                        ent.r0 = content_res(text_byte);
                    end
                end
                MODE_INT, MODE_FRAC:
                begin
                    if (is_digit(text_byte))
                    begin
                        if (mode_reg == MODE_INT)
                            int_over_one_next = 1'b1;
                        has_res = 1'b1;
                        ent.r0  = content_res(text_byte);
                    end
                    else if (mode_reg == MODE_INT && text_byte == CH_DOT)
                    begin
                        mode_next = MODE_DOT;
                        has_res   = 1'b1;
                        ent.r0    = content_res(text_byte);
                    end
                    else
                    begin
                        mode_next         = b_mode;
                        kw_target_next    = b_target;
                        kw_pos_next       = b_pos;
                        kw_match_next     = b_match;
                        lead_zero_next    = b_lead_zero;
                        int_over_one_next = 1'b0;
                        has_res           = 1'b1;
                        ent.two           = b_has;
                        ent.r0            = complete_res(fin_type);
                        ent.r1            = b_res;
                    end
                end
                MODE_DOT:
                begin
                    has_res = 1'b1;
                    if (is_digit(text_byte))
                    begin
                        mode_next = MODE_FRAC;
                        ent.r0    = content_res(text_byte);
                    end
                    else if (is_space(text_byte))
                    begin
                        mode_next         = MODE_IDLE;
                        lead_zero_next    = 1'b0;
                        int_over_one_next = 1'b0;
                        ent.r0            = complete_res(TOK_GARBAGE);
                    end
                    else
                    begin
                        mode_next = MODE_GARBAGE;
                        ent.r0    = content_res(text_byte);
                    end
                end
                MODE_GARBAGE:
                begin
                    has_res = 1'b1;
                    if (is_space(text_byte))
                    begin
                        mode_next         = MODE_IDLE;
                        kw_target_next    = KW_NONE;
                        kw_pos_next       = 3'd0;
                        kw_match_next     = 1'b0;
                        lead_zero_next    = 1'b0;
                        int_over_one_next = 1'b0;
                        ent.r0            = complete_res(TOK_GARBAGE);
                    end
                    else
                    begin
                        ent.r0 = content_res(text_byte);
                    end
                end
                default:
                begin
                    // Idle, and the unused mode code, start a new token
                    mode_next         = b_mode;
                    kw_target_next    = b_target;
                    kw_pos_next       = b_pos;
                    kw_match_next     = b_match;
                    lead_zero_next    = b_lead_zero;
                    int_over_one_next = 1'b0;
                    has_res           = b_has;
                    ent.r0            = b_res;
                end
            endcase
        end
    end

    // Advance the scanner state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            kw_target_reg    <= KW_NONE;
            kw_pos_reg       <= 3'd0;
            kw_match_reg     <= 1'b0;
            lead_zero_reg    <= 1'b0;
            int_over_one_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            kw_target_reg    <= kw_target_next;
            kw_pos_reg       <= kw_pos_next;
            kw_match_reg     <= kw_match_next;
            lead_zero_reg    <= lead_zero_next;
            int_over_one_reg <= int_over_one_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/jts_fifo.sv
// Small queue of result entries between scanner and serializer.
// Uses jts_pkg for the entry type.
`default_nettype none

module jts_fifo #(
    parameter int DEPTH = jts_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire jts_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output jts_pkg::entry_t      pop_entry,
    output logic                 empty
);
    import jts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          storage_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = storage_reg[rd_ptr_reg];

    // Wrap pointers and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry slot
    always_ff @(posedge clk)
    begin
        if (do_push)
            storage_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

>>> hdl/jts_back.sv
// Output serializer: takes queue entries and sends their one or two
// results on the master stream, marking the final one. Uses jts_pkg.
`default_nettype none

module jts_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          empty,
    output logic                               pop,
    input  wire jts_pkg::entry_t               pop_entry,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [jts_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import jts_pkg::*;

    logic    hold_valid_reg, hold_valid_next;
    entry_t  hold_reg, hold_next;
    logic    phase_reg, phase_next;
    result_t cur;
    logic    out_fire, out_done, out_adv;

    assign cur      = phase_reg ? hold_reg.r1 : hold_reg.r0;
    assign m_tvalid = hold_valid_reg;
    assign m_tuser  = cur.ev;
    assign m_tdata  = {(TDATA_W - 12)'(0), cur.ttype, cur.data};
    assign m_tlast  = !hold_reg.two || phase_reg;

    assign out_fire = hold_valid_reg && m_tready;
    assign out_done = out_fire && (!hold_reg.two || phase_reg);
    assign out_adv  = out_fire && hold_reg.two && !phase_reg;
    assign pop      = !empty && (!hold_valid_reg || out_done);

    // Load the next entry, step to its second result, or drop it
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        phase_next      = phase_reg;
        if (pop)
        begin
            hold_valid_next = 1'b1;
            hold_next       = pop_entry;
            phase_next      = 1'b0;
        end
        else if (out_done)
        begin
            hold_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (out_adv)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
        end
    end

    // Entry payload needs no reset
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire
